// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the least laxity ready queue.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/llrq_pkg.sv
// Package for the least laxity ready queue: sizes, codes and the
// controller/datapath interface structs. No dependencies.
package llrq_pkg;

   localparam int DEPTH  = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = 6;
   localparam int ID_W   = 16;
   localparam int LAX_W  = 32;
   localparam int ENT_W  = ID_W + LAX_W;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(32);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LEAST  = 2'd2,
      OP_FRONT  = 2'd3
   } opcode_type;

   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_MISS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_TAIL,
      ST_POST,
      ST_SHIFT,
      ST_STAIL,
      ST_REPLY
   } ctl_state_type;

   typedef struct packed {
      logic       load;
      logic       scan_init;
      logic       scan_step;
      logic       shift_init;
      logic       shift_step;
      logic       finish;
      logic       with_data;
      logic       count_inc;
      logic       count_dec;
      logic       ins_write;
      logic [1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       empty;
      logic       full;
      logic       idx_zero;
      logic       idx_last;
      logic       found;
      logic       hit_last;
      logic       out_busy;
   } dp_stat_type;

endpackage

// File: rtl/llrq_ctrl.sv
// Controller FSM of the least laxity ready queue: sequences scan, shift and reply.
// Depends on llrq_pkg.
module llrq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  llrq_pkg::dp_stat_type stat,
   output llrq_pkg::dp_cmd_type  cmd
);
   import llrq_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.op == OP_INSERT || stat.empty) begin
               state_in = ST_REPLY;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.idx_zero) state_in = ST_TAIL;
         end
         ST_TAIL: begin
            state_in = ST_POST;
         end
         ST_POST: begin
            if (stat.op == OP_REMOVE && stat.found && !stat.hit_last) begin
               cmd.shift_init = 1'b1;
               state_in       = ST_SHIFT;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.idx_last) state_in = ST_STAIL;
         end
         ST_STAIL: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               cmd.status = STAT_DONE;
               state_in   = ST_IDLE;
               unique case (stat.op)
                  OP_INSERT: begin
                     if (stat.full) begin
                        cmd.status = STAT_FULL;
                     end else begin
                        cmd.ins_write = 1'b1;
                        cmd.count_inc = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (stat.found) cmd.count_dec = 1'b1;
                     else cmd.status = STAT_MISS;
                  end
                  OP_LEAST, OP_FRONT: begin
                     if (stat.empty) cmd.status = STAT_MISS;
                     else cmd.with_data = 1'b1;
                  end
                  default: cmd.status = STAT_MISS;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/llrq_dp.sv
// Datapath of the least laxity ready queue: entry memory, scan compare,
// shift, count, capacity and result word register. Depends on llrq_pkg.
module llrq_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  llrq_pkg::dp_cmd_type        cmd,
   output llrq_pkg::dp_stat_type       stat,
   input  llrq_pkg::opcode_type        req_op,
   input  logic [llrq_pkg::ID_W-1:0]   req_id,
   input  logic [llrq_pkg::LAX_W-1:0]  req_lax,
   input  logic                        csr_valid,
   input  logic [llrq_pkg::CNT_W-1:0]  csr_cap,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [llrq_pkg::ID_W-1:0]   rsp_id,
   output logic [llrq_pkg::LAX_W-1:0]  rsp_lax,
   output logic                        rsp_empty,
   output logic                        rsp_full,
   output logic [llrq_pkg::CNT_W-1:0]  rsp_count
);
   import llrq_pkg::*;

   logic [ENT_W-1:0] mem [DEPTH];

   opcode_type        op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [LAX_W-1:0]  lax_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  limit;
   logic [CNT_W-1:0]  last_idx;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic [CNT_W-1:0]  hit_ff;
   logic              scan_pend_ff, shift_pend_ff;
   logic              first_ff, found_ff;
   logic [ENT_W-1:0]  rdata_ff;
   logic [ENT_W-1:0]  best_ff;
   logic [ID_W-1:0]   rd_id;
   logic [LAX_W-1:0]  rd_lax;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [ENT_W-1:0]  wdata;
   logic              rsp_valid_ff;
   logic [1:0]        status_ff;
   logic [ID_W-1:0]   rid_ff;
   logic [LAX_W-1:0]  rlax_ff;
   logic              empty_ff, full_ff;
   logic [CNT_W-1:0]  rcount_ff;

   assign limit    = (cap_ff < DEPTH_CNT) ? cap_ff : DEPTH_CNT;
   assign last_idx = count_ff - CNT_W'(1);
   assign rd_id    = rdata_ff[ENT_W-1:LAX_W];
   assign rd_lax   = rdata_ff[LAX_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) count_in = count_ff + CNT_W'(1);
      else if (cmd.count_dec) count_in = count_ff - CNT_W'(1);
   end

   // memory write: insert at the tail, or shift one entry down
   always_comb begin
      we    = 1'b0;
      waddr = count_ff[ADDR_W-1:0];
      wdata = {id_ff, lax_ff};
      if (cmd.ins_write) begin
         we = 1'b1;
      end else if (shift_pend_ff) begin
         we    = 1'b1;
         waddr = ADDR_W'(rd_idx_ff - CNT_W'(1));
         wdata = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         cap_ff        <= CAP_RESET;
         scan_pend_ff  <= 1'b0;
         shift_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         scan_pend_ff  <= cmd.scan_step;
         shift_pend_ff <= cmd.shift_step;
         if (csr_valid) cap_ff <= csr_cap;
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         id_ff    <= req_id;
         lax_ff   <= req_lax;
         first_ff <= 1'b1;
         found_ff <= 1'b0;
      end
      if (cmd.scan_init) begin
         idx_ff <= (op_ff == OP_FRONT) ? '0 : last_idx;
      end else if (cmd.shift_init) begin
         idx_ff <= hit_ff + CNT_W'(1);
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff - CNT_W'(1);
      end else if (cmd.shift_step) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmd.scan_step || cmd.shift_step) rd_idx_ff <= idx_ff;
      // scan runs newest to oldest: strict less keeps the newest of equals
      if (scan_pend_ff) begin
         first_ff <= 1'b0;
         if (first_ff || $signed(rd_lax) < $signed(best_ff[LAX_W-1:0])) begin
            best_ff <= rdata_ff;
         end
         if (!found_ff && rd_id == id_ff) begin
            found_ff <= 1'b1;
            hit_ff   <= rd_idx_ff;
         end
      end
      if (cmd.finish) begin
         status_ff <= cmd.status;
         rid_ff    <= cmd.with_data ? best_ff[ENT_W-1:LAX_W] : '0;
         rlax_ff   <= cmd.with_data ? best_ff[LAX_W-1:0] : '0;
         empty_ff  <= (count_in == '0);
         full_ff   <= (count_in >= limit);
         rcount_ff <= count_in;
      end
   end

   always_comb begin
      stat.op       = op_ff;
      stat.empty    = (count_ff == '0);
      stat.full     = (count_ff >= limit);
      stat.idx_zero = (idx_ff == '0);
      stat.idx_last = (idx_ff == last_idx);
      stat.found    = found_ff;
      stat.hit_last = (hit_ff == last_idx);
      stat.out_busy = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_id     = rid_ff;
   assign rsp_lax    = rlax_ff;
   assign rsp_empty  = empty_ff;
   assign rsp_full   = full_ff;
   assign rsp_count  = rcount_ff;

endmodule

// File: rtl/least_laxity_ready_queue_core.sv
// Order of work: insert, or any word on an empty queue, goes straight to the reply; least
// laxity, remove and front scan the entry memory, and a removal that hits shifts later entries down.
// Handshake: one word at a time; the next is taken in the cycle after the result loads, and a
// result still held by the receiver stalls the reply.
// Reset: synchronous, active high; empties the queue, capacity 32; entry memory not cleared.
// Depends on llrq_pkg, llrq_ctrl, llrq_dp and assert_macros.svh.
`include "assert_macros.svh"
module least_laxity_ready_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // opcode[1:0], job_id[17:2], laxity[49:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // status[1:0], found_id[17:2], found_laxity[49:18],
                                    // is_empty[50], is_full[51], job_count[57:52]
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata    // capacity[5:0]
);
   import llrq_pkg::*;

   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [1:0]       rsp_status;
   logic [ID_W-1:0]  rsp_id;
   logic [LAX_W-1:0] rsp_lax;
   logic             rsp_empty, rsp_full;
   logic [CNT_W-1:0] rsp_count;

   assign csr_tready = 1'b1;

   llrq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   llrq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (opcode_type'(req_tdata[1:0])),
      .req_id     (req_tdata[17:2]),
      .req_lax    (req_tdata[49:18]),
      .csr_valid  (csr_tvalid),
      .csr_cap    (csr_tdata[5:0]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_id     (rsp_id),
      .rsp_lax    (rsp_lax),
      .rsp_empty  (rsp_empty),
      .rsp_full   (rsp_full),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {6'd0, rsp_count, rsp_full, rsp_empty, rsp_lax, rsp_id, rsp_status};

   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPL(a_count_bound, clock, reset, rsp_tvalid, rsp_count <= DEPTH_CNT)
   `ASSERT_IMPL(a_empty_flag, clock, reset, rsp_tvalid, rsp_empty == (rsp_count == '0))
   `ASSERT_IMPL(a_miss_no_data, clock, reset, rsp_tvalid && rsp_status != STAT_DONE,
                rsp_id == '0 && rsp_lax == '0)

endmodule

// File: bench/tb_least_laxity_ready_queue_core.sv
// Self-checking bench for least_laxity_ready_queue_core: a directed table and
// then random job words, checked against an in-bench model of the ready queue.
// Depends on llrq_pkg and the core RTL.
module tb_least_laxity_ready_queue_core;
   import llrq_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int SEGMENTS    = 8;
   localparam int SEG_WORDS   = 50;

   typedef struct packed {
      opcode_type         op;
      logic [15:0]        job_id;
      logic signed [31:0] laxity;
   } job_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        found_id;
      logic signed [31:0] found_laxity;
      logic               is_empty;
      logic               is_full;
      logic [5:0]         job_count;
   } queue_reply_type;

   typedef enum bit {ROW_JOB, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [5:0]      cap;
      job_word_type    word;
      bit              typed;
      queue_reply_type reply;
   } plan_row_type;

   localparam queue_reply_type EMPTY_MISS = '{STAT_MISS, 16'h0, 32'sh0, 1'b1, 1'b0, 6'd0};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [55:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_tvalid = 1'b0;
   logic [7:0]  csr_tdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [63:0] rsp_tdata;
   logic        csr_tready;

   // model of the queue
   logic [15:0]        rq_ids [DEPTH];
   logic signed [31:0] rq_lax [DEPTH];
   int                 rq_count    = 0;
   logic [5:0]         rq_capacity = CAP_RESET;

   queue_reply_type expected_replies[$];
   int              mismatches   = 0;
   int              random_words = 0;
   int              cycle_count  = 0;
   int              tx_idle_pct  = 35;
   int              rx_idle_pct  = 85;
   logic            rx_hold      = 1'b0;

   least_laxity_ready_queue_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic queue_reply_type ready_queue_step(job_word_type w);
      queue_reply_type r;
      int              lim;
      int              hit;
      int              best;
      r   = '0;
      lim = (rq_capacity < DEPTH) ? int'(rq_capacity) : DEPTH;
      r.status = STAT_DONE;
      case (w.op)
         OP_INSERT: begin
            if (rq_count >= lim) begin
               r.status = STAT_FULL;
            end else begin
               rq_ids[rq_count] = w.job_id;
               rq_lax[rq_count] = w.laxity;
               rq_count++;
            end
         end
         OP_REMOVE: begin
            hit = -1;
            for (int i = 0; i < rq_count; i++)
               if (rq_ids[i] == w.job_id) hit = i;
            if (hit < 0) begin
               r.status = STAT_MISS;
            end else begin
               for (int i = hit; i < rq_count - 1; i++) begin
                  rq_ids[i] = rq_ids[i+1];
                  rq_lax[i] = rq_lax[i+1];
               end
               rq_count--;
            end
         end
         OP_LEAST: begin
            if (rq_count == 0) begin
               r.status = STAT_MISS;
            end else begin
               // newest first, strict less-than: ties go to the newest
               best = rq_count - 1;
               for (int i = rq_count - 2; i >= 0; i--)
                  if (rq_lax[i] < rq_lax[best]) best = i;
               r.found_id     = rq_ids[best];
               r.found_laxity = rq_lax[best];
            end
         end
         default: begin
            if (rq_count == 0) begin
               r.status = STAT_MISS;
            end else begin
               r.found_id     = rq_ids[0];
               r.found_laxity = rq_lax[0];
            end
         end
      endcase
      r.is_empty  = (rq_count == 0);
      r.is_full   = (rq_count >= lim);
      r.job_count = 6'(rq_count);
      return r;
   endfunction

   function automatic job_word_type random_job(int insert_pct);
      job_word_type w;
      int           pick;
      if ($urandom_range(99) < insert_pct)
         w.op = OP_INSERT;
      else
         w.op = opcode_type'(2'($urandom_range(3, 1)));
      w.job_id = ($urandom_range(99) < 70) ? 16'($urandom_range(15)) : 16'($urandom);
      if (w.op == OP_REMOVE && rq_count > 0 && $urandom_range(99) < 80)
         w.job_id = rq_ids[$urandom_range(rq_count - 1)];
      pick = $urandom_range(99);
      if (pick < 40)
         w.laxity = 32'((int'($urandom_range(4)) - 2) * 65536);
      else if (pick < 50)
         w.laxity = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else
         w.laxity = $urandom;
      return w;
   endfunction

   task automatic send_job(job_word_type w, bit typed, queue_reply_type typed_reply);
      queue_reply_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, w.laxity, w.job_id, w.op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = ready_queue_step(w);
      expected_replies.push_back(typed ? typed_reply : predicted);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [5:0] cap);
      wait_drained();
      csr_tvalid <= 1'b1;
      csr_tdata  <= {2'b00, cap};
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid  <= 1'b0;
      rq_capacity = cap;
   endtask

   always @(posedge clock) begin : rsp_side
      queue_reply_type got;
      queue_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[1:0], rsp_tdata[17:2], rsp_tdata[49:18],
                   rsp_tdata[50], rsp_tdata[51], rsp_tdata[57:52]};
            if (expected_replies.size() == 0) begin
               $error("reply word with nothing expected: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.found_id !== want.found_id) begin
                  $error("found_id: expected %0d, got %0d", want.found_id, got.found_id);
                  mismatches++;
               end
               if (got.found_laxity !== want.found_laxity) begin
                  $error("found_laxity: expected %0d, got %0d",
                         want.found_laxity, got.found_laxity);
                  mismatches++;
               end
               if (got.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                  mismatches++;
               end
               if (got.is_full !== want.is_full) begin
                  $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
                  mismatches++;
               end
               if (got.job_count !== want.job_count) begin
                  $error("job_count: expected %0d, got %0d", want.job_count, got.job_count);
                  mismatches++;
               end
            end
         end
         rsp_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // long receiver stall so the core backs up and stalls its input
   initial begin : rx_holdoff
      wait (random_words == 120);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   initial begin : stimulus
      plan_row_type plan[$];
      int           seg_insert_pct [SEGMENTS] = '{85, 40, 70, 30, 55, 60, 75, 45};
      logic [5:0]   seg_capacity [SEGMENTS] = '{6'd63, 6'd1, 6'd32, 6'd0,
                                                6'd7, 6'd20, 6'd33, 6'd12};
      int           phase;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      plan.push_back('{ROW_JOB, 6'd0, '{OP_FRONT, 16'h0000, 32'sh0}, 1'b1, EMPTY_MISS});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_LEAST, 16'h0000, 32'sh0}, 1'b1, EMPTY_MISS});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_REMOVE, 16'h0000, 32'sh0}, 1'b1, EMPTY_MISS});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_INSERT, 16'hFFFF, 32'sh7FFF_FFFF}, 1'b1,
                       '{STAT_DONE, 16'h0, 32'sh0, 1'b0, 1'b0, 6'd1}});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_INSERT, 16'h0000, 32'sh8000_0000}, 1'b1,
                       '{STAT_DONE, 16'h0, 32'sh0, 1'b0, 1'b0, 6'd2}});
      // equal least laxity: newer entry wins
      plan.push_back('{ROW_JOB, 6'd0, '{OP_INSERT, 16'h1234, 32'sh8000_0000}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_LEAST, 16'h0000, 32'sh0}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_FRONT, 16'hFFFF, 32'shFFFF_FFFF}, 1'b0, '0});
      // duplicate id: remove takes the newest
      plan.push_back('{ROW_JOB, 6'd0, '{OP_INSERT, 16'h1234, 32'sh0000_0005}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_REMOVE, 16'h1234, 32'sh0}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_LEAST, 16'h0000, 32'sh0}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_REMOVE, 16'h5555, 32'sh0}, 1'b0, '0});
      // capacity below the count
      plan.push_back('{ROW_CFG, 6'd2, '0, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_INSERT, 16'h0F0F, 32'sh0001_0000}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_REMOVE, 16'hFFFF, 32'sh0}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_REMOVE, 16'h0000, 32'sh0}, 1'b0, '0});
      plan.push_back('{ROW_CFG, 6'd0, '0, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_INSERT, 16'hAAAA, 32'shFFFF_FFFF}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_REMOVE, 16'h1234, 32'sh0}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_INSERT, 16'h5555, 32'sh0}, 1'b1,
                       '{STAT_FULL, 16'h0, 32'sh0, 1'b1, 1'b1, 6'd0}});
      // capacity above depth clamps to depth
      plan.push_back('{ROW_CFG, 6'd63, '0, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_INSERT, 16'h0002, 32'shC000_0000}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_LEAST, 16'h0000, 32'sh0}, 1'b0, '0});
      plan.push_back('{ROW_JOB, 6'd0, '{OP_FRONT, 16'h0000, 32'sh0}, 1'b0, '0});

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CFG)
            write_capacity(plan[k].cap);
         else
            send_job(plan[k].word, plan[k].typed, plan[k].reply);
      end

      seg_capacity[5] = 6'($urandom_range(31, 2));
      seg_capacity[7] = 6'($urandom_range(63));
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         phase = seg * 3 / SEGMENTS;
         tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 85 : 0;
         rx_idle_pct <= (phase == 0) ? 85 : (phase == 1) ? 35 : 0;
         write_capacity(seg_capacity[seg]);
         for (int n = 0; n < SEG_WORDS; n++) begin
            if (seg == 5 && n == SEG_WORDS / 2) wait_drained();
            send_job(random_job(seg_insert_pct[seg]), 1'b0, '0);
            random_words++;
         end
      end

      wait_drained();
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
